FILE: rtl/core/wnes_pkg.sv
// Shared types and codes for the weighted nearest entry search block.
package wnes_pkg;

    localparam int NFEAT = 6;

    typedef enum logic [1:0] {
        OP_STAGE  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOSTAGED = 2'd3
    } status_t;

    // One stored entry: six signed targets and six clamped weights
    typedef struct packed {
        logic [NFEAT-1:0][15:0] tgt;
        logic [NFEAT-1:0][14:0] wgt;
    } entry_t;

endpackage

FILE: rtl/core/wnes_cell.sv
// One table slot of the entry ring: loads an appended entry or takes its neighbour's.
module wnes_cell
(
    input  logic            clk,
    input  logic            load_en,
    input  wnes_pkg::entry_t load_data,
    input  logic            shift_en,
    input  wnes_pkg::entry_t neighbour,
    output wnes_pkg::entry_t data
);

    wnes_pkg::entry_t data_reg;

    // Hold, load a new entry, or advance the ring by one slot
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            data_reg <= load_data;
        end
        else if (shift_en)
        begin
            data_reg <= neighbour;
        end
    end

    assign data = data_reg;

endmodule

FILE: rtl/core/wnes_dist.sv
// Three-stage pipelined weighted squared distance of one entry against the query.
module wnes_dist #(
    parameter int IW = 6
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [IW-1:0]                         in_idx,
    input  wnes_pkg::entry_t                      entry,
    input  logic [wnes_pkg::NFEAT-1:0][15:0]      feat,
    output logic                                  out_valid,
    output logic [IW-1:0]                         out_idx,
    output logic [49:0]                           out_dist
);

    logic [wnes_pkg::NFEAT-1:0][31:0] sq_reg;
    logic [wnes_pkg::NFEAT-1:0][14:0] w1_reg;
    logic [wnes_pkg::NFEAT-1:0][46:0] prod_reg;
    logic [49:0]                      sum_reg;
    logic [2:0]                       vld_reg;
    logic [IW-1:0]                    idx1_reg;
    logic [IW-1:0]                    idx2_reg;
    logic [IW-1:0]                    idx3_reg;
    logic [wnes_pkg::NFEAT-1:0][15:0] mag;
    logic [49:0]                      sum_next;

    // Absolute difference per lane, exact in 16 bits
    always_comb
    begin
        logic signed [16:0] diff;
        for (int k = 0; k < wnes_pkg::NFEAT; k++)
        begin
            diff = {entry.tgt[k][15], entry.tgt[k]} - {feat[k][15], feat[k]};
            mag[k] = diff[16] ? 16'(-diff) : diff[15:0];
        end
    end

    // Sum the six weighted terms
    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < wnes_pkg::NFEAT; k++)
        begin
            sum_next = sum_next + 50'(prod_reg[k]);
        end
    end

    // Advance the valid tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // Square, weight, sum
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < wnes_pkg::NFEAT; k++)
        begin
            sq_reg[k]   <= mag[k] * mag[k];
            w1_reg[k]   <= entry.wgt[k];
            prod_reg[k] <= sq_reg[k] * w1_reg[k];
        end
        sum_reg  <= sum_next;
        idx1_reg <= in_idx;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
    end

    assign out_valid = vld_reg[2];
    assign out_idx   = idx3_reg;
    assign out_dist  = sum_reg;

endmodule

FILE: rtl/core/weighted_nearest_entry_search.sv
// Weighted nearest entry search: stages, appends, clears and queries a ring of table entries.
// Stage, append and clear are answered from a registered result. A query rotates the ring of
// MAX_ENTRIES cells through one shared three-stage distance unit, one entry per cycle, and
// drains that unit before its transaction is offered (an empty table is answered directly).
// A new transaction is taken once the output is empty or in the cycle that the waiting result
// is taken, as long as no query is in progress.
module weighted_nearest_entry_search #(
    parameter int MAX_ENTRIES = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic signed [15:0]  val_humidity,
    input  logic signed [15:0]  val_temperature,
    input  logic signed [15:0]  val_weirdness,
    input  logic signed [15:0]  val_erosion,
    input  logic signed [15:0]  val_elevation,
    input  logic signed [15:0]  val_surface,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [5:0]          best_index,
    output logic [49:0]         best_distance
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [CW-1:0]                     count_reg;
    logic                              staged_valid_reg;
    logic [wnes_pkg::NFEAT-1:0][15:0]  staged_reg;
    logic [wnes_pkg::NFEAT-1:0][15:0]  feat_reg;
    logic [IW-1:0]                     scan_reg;
    logic [1:0]                        drain_reg;
    logic                              found_reg;
    logic [IW-1:0]                     best_idx_reg;
    logic [49:0]                       best_dist_reg;
    logic                              out_valid_reg;
    logic [1:0]                        status_reg;
    logic [5:0]                        index_reg;
    logic [49:0]                       dist_reg;

    logic [wnes_pkg::NFEAT-1:0][15:0]  vals;
    logic                              accept;
    logic                              out_free;
    logic                              do_append;
    logic                              shift_en;
    wnes_pkg::entry_t                  new_entry;
    wnes_pkg::entry_t                  cell_data [MAX_ENTRIES];
    logic                              d_valid;
    logic [IW-1:0]                     d_idx;
    logic [49:0]                       d_dist;
    logic [IW+5:0]                     idx_ext;
    logic [IW+5:0]                     cnt_ext;
    logic                              scan_live;

    assign vals = {val_surface, val_elevation, val_erosion,
                   val_weirdness, val_temperature, val_humidity};

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !(state_reg == S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    assign do_append = accept && (op == wnes_pkg::OP_APPEND) && staged_valid_reg
                       && (count_reg != CW'(MAX_ENTRIES));
    assign shift_en  = (state_reg == S_SCAN);

    // Build the entry to append, clamping negative weights to zero
    always_comb
    begin
        new_entry.tgt = staged_reg;
        for (int k = 0; k < wnes_pkg::NFEAT; k++)
        begin
            new_entry.wgt[k] = vals[k][15] ? 15'd0 : vals[k][14:0];
        end
    end

    // Ring of cells, slot zero feeds the distance unit
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        wnes_cell u_cell
        (
            .clk       (clk),
            .load_en   (do_append && (count_reg == CW'(i))),
            .load_data (new_entry),
            .shift_en  (shift_en),
            .neighbour (cell_data[(i + 1) % MAX_ENTRIES]),
            .data      (cell_data[i])
        );
    end

    assign scan_live = ({{(CW){1'b0}}, scan_reg} < {{(IW){1'b0}}, count_reg});

    wnes_dist #(.IW(IW)) u_dist
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (shift_en && scan_live),
        .in_idx    (scan_reg),
        .entry     (cell_data[0]),
        .feat      (feat_reg),
        .out_valid (d_valid),
        .out_idx   (d_idx),
        .out_dist  (d_dist)
    );

    // Sequence the query scan
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == wnes_pkg::OP_QUERY) && (count_reg != '0))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_reg == IW'(MAX_ENTRIES - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (drain_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            staged_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            scan_reg         <= '0;
            drain_reg        <= '0;
            found_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                case (op)
                    wnes_pkg::OP_STAGE:  staged_valid_reg <= 1'b1;
                    wnes_pkg::OP_APPEND:
                    begin
                        if (do_append)
                        begin
                            count_reg        <= count_reg + 1'b1;
                            staged_valid_reg <= 1'b0;
                        end
                    end
                    wnes_pkg::OP_CLEAR:  count_reg <= '0;
                    default:             found_reg <= 1'b0;
                endcase
            end
            scan_reg  <= shift_en ? scan_reg + 1'b1 : '0;
            drain_reg <= (state_reg == S_DRAIN) ? drain_reg + 1'b1 : 2'd0;
            if (d_valid)
            begin
                found_reg <= 1'b1;
            end
            // Hold the output until taken; load on a new result
            if ((accept && !(op == wnes_pkg::OP_QUERY && count_reg != '0))
                || (state_reg == S_DONE && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign idx_ext = {6'd0, best_idx_reg};
    assign cnt_ext = {{(IW + 6 - CW){1'b0}}, count_reg};

    // Payload: staged targets, features, running best, output register
    always_ff @(posedge clk)
    begin
        if (accept && op == wnes_pkg::OP_STAGE)
        begin
            staged_reg <= vals;
        end
        if (accept && op == wnes_pkg::OP_QUERY)
        begin
            feat_reg <= vals;
        end
        // Strict compare keeps the lowest index on a tie
        if (d_valid && (!found_reg || d_dist < best_dist_reg))
        begin
            best_dist_reg <= d_dist;
            best_idx_reg  <= d_idx;
        end
        if (accept)
        begin
            status_reg <= wnes_pkg::ST_OK;
            index_reg  <= '0;
            dist_reg   <= '0;
            case (op)
                wnes_pkg::OP_APPEND:
                begin
                    if (!staged_valid_reg)
                    begin
                        status_reg <= wnes_pkg::ST_NOSTAGED;
                    end
                    else if (count_reg == CW'(MAX_ENTRIES))
                    begin
                        status_reg <= wnes_pkg::ST_FULL;
                    end
                    else
                    begin
                        index_reg <= cnt_ext[5:0];
                    end
                end
                wnes_pkg::OP_QUERY:
                begin
                    if (count_reg == '0)
                    begin
                        status_reg <= wnes_pkg::ST_EMPTY;
                    end
                end
                default:
                begin
                    status_reg <= wnes_pkg::ST_OK;
                end
            endcase
        end
        else if (state_reg == S_DONE && out_free)
        begin
            status_reg <= wnes_pkg::ST_OK;
            index_reg  <= idx_ext[5:0];
            dist_reg   <= best_dist_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign best_index    = index_reg;
    assign best_distance = dist_reg;

    // Table never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond capacity");

    // Distance results only arrive while a query is running
    a_dist_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("distance result outside a query");

    // A query on a non-empty table starts the scan
    a_query_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == wnes_pkg::OP_QUERY && count_reg != '0) |=> state_reg == S_SCAN)
        else $error("query did not start scan");

endmodule

FILE: bench/weighted_nearest_entry_search_tb.sv
// Self-checking bench for the weighted nearest entry search block.
`timescale 1ns / 1ps

module weighted_nearest_entry_search_tb;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        wnes_pkg::op_t     op;
        logic [5:0][15:0]  vals;
    } cmd_t;

    typedef struct packed {
        wnes_pkg::status_t st;
        logic [5:0]        idx;
        logic [49:0]       distance;
    } answer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] op;
    logic signed [15:0] val_humidity, val_temperature, val_weirdness;
    logic signed [15:0] val_erosion, val_elevation, val_surface;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic [5:0] best_index;
    logic [49:0] best_distance;

    weighted_nearest_entry_search #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .val_humidity(val_humidity), .val_temperature(val_temperature),
        .val_weirdness(val_weirdness), .val_erosion(val_erosion),
        .val_elevation(val_elevation), .val_surface(val_surface),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .best_index(best_index), .best_distance(best_distance)
    );

    // Predictor state
    logic signed [15:0] tgt_mem [TABLE_DEPTH][6];
    logic [15:0]        wgt_mem [TABLE_DEPTH][6];
    logic signed [15:0] staged [6];
    bit                 staged_ok;
    int                 n_entries;

    cmd_t    pending_cmds[$];
    answer_t expected_answers[$];
    bit      failed;
    bit      stim_done;
    bit      hold_rx;
    int      cycles;

    // Work out the answer to one accepted transaction
    function automatic answer_t predict_answer(cmd_t c);
        answer_t a;
        logic signed [15:0] v [6];
        logic [49:0] sum, best;
        logic signed [16:0] diff;
        logic [16:0] mag;
        a = '0;
        for (int k = 0; k < 6; k++)
            v[k] = c.vals[k];
        case (c.op)
            wnes_pkg::OP_STAGE:
            begin
                for (int k = 0; k < 6; k++)
                    staged[k] = v[k];
                staged_ok = 1;
            end
            wnes_pkg::OP_APPEND:
            begin
                if (!staged_ok)
                    a.st = wnes_pkg::ST_NOSTAGED;
                else if (n_entries >= TABLE_DEPTH)
                    a.st = wnes_pkg::ST_FULL;
                else
                begin
                    for (int k = 0; k < 6; k++)
                    begin
                        tgt_mem[n_entries][k] = staged[k];
                        wgt_mem[n_entries][k] = v[k] < 0 ? 16'd0 : v[k];
                    end
                    a.idx = n_entries[5:0];
                    n_entries++;
                    staged_ok = 0;
                end
            end
            wnes_pkg::OP_QUERY:
            begin
                if (n_entries == 0)
                    a.st = wnes_pkg::ST_EMPTY;
                else
                begin
                    best = '1;
                    for (int e = 0; e < n_entries; e++)
                    begin
                        sum = '0;
                        for (int k = 0; k < 6; k++)
                        begin
                            diff = 17'(tgt_mem[e][k]) - 17'(v[k]);
                            mag = diff < 0 ? 17'(-diff) : 17'(diff);
                            sum += 50'(mag) * 50'(mag) * 50'(wgt_mem[e][k]);
                        end
                        if (e == 0 || sum < best)
                        begin
                            best = sum;
                            a.idx = e[5:0];
                        end
                    end
                    a.distance = best;
                end
            end
            default:
                n_entries = 0;
        endcase
        return a;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 2);
    endfunction

    function automatic logic [15:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 8191)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cmd_t make_cmd(wnes_pkg::op_t o, logic [15:0] v);
        cmd_t c;
        c.op = o;
        for (int k = 0; k < 6; k++)
            c.vals[k] = v;
        return c;
    endfunction

    function automatic cmd_t rand_cmd(wnes_pkg::op_t o);
        cmd_t c;
        c.op = o;
        for (int k = 0; k < 6; k++)
            c.vals[k] = rand_val();
        return c;
    endfunction

    // Append one transaction to the pending queue
    function automatic void queue_cmd(cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Driver: offer queued transactions with random gaps
    int send_gap;
    bit quiesce;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= '0;
            {val_humidity, val_temperature, val_weirdness} <= '0;
            {val_erosion, val_elevation, val_surface} <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_answers.insert(expected_answers.size(),
                                        predict_answer(pending_cmds.pop_front()));
                send_gap = gap_len();
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0 && !quiesce)
                begin
                    in_valid <= 1'b1;
                    op <= pending_cmds[0].op;
                    val_humidity <= pending_cmds[0].vals[0];
                    val_temperature <= pending_cmds[0].vals[1];
                    val_weirdness <= pending_cmds[0].vals[2];
                    val_erosion <= pending_cmds[0].vals[3];
                    val_elevation <= pending_cmds[0].vals[4];
                    val_surface <= pending_cmds[0].vals[5];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transaction and stall at random
    int rx_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d index=%0d distance=%0d",
                             $time, status, best_index, best_distance);
                    failed = 1;
                end
                else
                begin
                    answer_t a;
                    a = expected_answers.pop_front();
                    if (status !== a.st || best_index !== a.idx
                        || best_distance !== a.distance)
                    begin
                        $display("%0t: expected st=%0d idx=%0d d=%0d, got st=%0d idx=%0d d=%0d",
                                 $time, a.st, a.idx, a.distance, status, best_index,
                                 best_distance);
                        failed = 1;
                    end
                end
            end
            if (hold_rx)
                out_stall <= 1'b1;
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                rx_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                out_stall <= (rx_gap > 0);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering
    initial
    begin
        hold_rx = 0;
        wait (pending_cmds.size() > 0 && rst_n);
        repeat (3000) @(posedge clk);
        hold_rx = 1;
        repeat (400) @(posedge clk);
        hold_rx = 0;
    end

    // Stimulus
    initial
    begin
        int n;
        failed = 0;
        quiesce = 0;
        cycles = 0;
        staged_ok = 0;
        n_entries = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty query, append without staging, extremes, ties, full table
        queue_cmd(make_cmd(wnes_pkg::OP_QUERY, 16'h0000));
        queue_cmd(make_cmd(wnes_pkg::OP_APPEND, 16'h1000));
        queue_cmd(make_cmd(wnes_pkg::OP_STAGE, 16'h8000));
        queue_cmd(make_cmd(wnes_pkg::OP_STAGE, 16'h7fff));
        queue_cmd(make_cmd(wnes_pkg::OP_APPEND, 16'h7fff));
        queue_cmd(make_cmd(wnes_pkg::OP_QUERY, 16'h8000));
        queue_cmd(make_cmd(wnes_pkg::OP_STAGE, 16'h7fff));
        queue_cmd(make_cmd(wnes_pkg::OP_APPEND, 16'hffff));
        queue_cmd(make_cmd(wnes_pkg::OP_QUERY, 16'h0000));
        queue_cmd(make_cmd(wnes_pkg::OP_STAGE, 16'h7fff));
        queue_cmd(make_cmd(wnes_pkg::OP_APPEND, 16'h7fff));
        queue_cmd(make_cmd(wnes_pkg::OP_QUERY, 16'h7fff));
        queue_cmd(make_cmd(wnes_pkg::OP_CLEAR, 16'h5555));
        queue_cmd(make_cmd(wnes_pkg::OP_QUERY, 16'haaaa));
        queue_cmd(make_cmd(wnes_pkg::OP_APPEND, 16'h0001));
        for (int i = 0; i < TABLE_DEPTH + 1; i++)
        begin
            queue_cmd(rand_cmd(wnes_pkg::OP_STAGE));
            queue_cmd(rand_cmd(wnes_pkg::OP_APPEND));
        end
        queue_cmd(rand_cmd(wnes_pkg::OP_QUERY));
        queue_cmd(rand_cmd(wnes_pkg::OP_APPEND));
        queue_cmd(rand_cmd(wnes_pkg::OP_QUERY));
        queue_cmd(make_cmd(wnes_pkg::OP_CLEAR, 16'h0000));

        // Sender pause until everything has drained
        wait (pending_cmds.size() == 0);
        quiesce = 1;
        wait (expected_answers.size() == 0);
        repeat (10) @(posedge clk);
        quiesce = 0;

        // Random: mostly stage/append pairs, queries, some noise and clears
        n = 0;
        while (n < 800)
        begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                queue_cmd(rand_cmd(wnes_pkg::OP_STAGE));
                queue_cmd(rand_cmd(wnes_pkg::OP_APPEND));
                n += 2;
            end
            else if (pick < 85)
            begin
                queue_cmd(rand_cmd(wnes_pkg::OP_QUERY));
                n++;
            end
            else if (pick < 88)
            begin
                queue_cmd(rand_cmd(wnes_pkg::OP_CLEAR));
                n++;
            end
            else
            begin
                queue_cmd(rand_cmd(wnes_pkg::op_t'($urandom_range(0, 1))));
                n++;
            end
        end

        wait (pending_cmds.size() == 0);
        wait (expected_answers.size() == 0);
        repeat (TABLE_DEPTH + 20) @(posedge clk);
        if (!failed)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/wnes_pkg.sv
rtl/core/wnes_cell.sv
rtl/core/wnes_dist.sv
rtl/core/weighted_nearest_entry_search.sv
bench/weighted_nearest_entry_search_tb.sv
